// ===== hdl/bda_pkg.sv =====
package bda_pkg;

  localparam int unsigned NUM_BTN   = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned KEY_OK     = 0;
  localparam int unsigned KEY_CANCEL = 1;
  localparam int unsigned KEY_LEFT   = 2;
  localparam int unsigned KEY_RIGHT  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd300;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_POLL   = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] rpt_ms;
  } cfg_t;

  typedef struct packed {
    logic              accept;
    logic              mode;
    logic [TIME_W-1:0] now_ms;
  } lane_ctl_t;

endpackage

// ===== hdl/bda_lane.sv =====
module bda_lane #(
  parameter bit AUTO_REPEAT = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bda_pkg::lane_ctl_t ctl,
  input  bda_pkg::cfg_t      cfg,
  input  logic               level,
  output logic               event_hit
);

  logic [bda_pkg::TIME_W-1:0] mark_r;
  logic [bda_pkg::TIME_W-1:0] mark_nxt;
  logic                       pressed_r;
  logic                       pressed_nxt;
  logic                       held_r;
  logic                       held_nxt;
  logic [bda_pkg::TIME_W-1:0] elapsed;
  logic                       gt_deb;
  logic                       gt_rpt;

  assign elapsed = ctl.now_ms - mark_r;
  assign gt_deb  = elapsed > {{(bda_pkg::TIME_W-bda_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
  assign gt_rpt  = elapsed > {{(bda_pkg::TIME_W-bda_pkg::CFG_W){1'b0}}, cfg.rpt_ms};

  always_comb begin
    mark_nxt    = mark_r;
    pressed_nxt = pressed_r;
    held_nxt    = held_r;
    event_hit   = 1'b0;
    if (ctl.accept) begin
      if (ctl.mode == bda_pkg::MODE_SAMPLE) begin
        if (!level) begin
          if (!pressed_r) begin
            mark_nxt    = ctl.now_ms;
            pressed_nxt = 1'b1;
            held_nxt    = 1'b0;
          end
        end else begin
          pressed_nxt = 1'b0;
          held_nxt    = 1'b0;
        end
      end else if (pressed_r) begin
        if (AUTO_REPEAT) begin
          if (!held_r) begin
            if (gt_deb) begin
              held_nxt  = 1'b1;
              mark_nxt  = ctl.now_ms;
              event_hit = 1'b1;
            end
          end else if (gt_rpt) begin
            mark_nxt  = ctl.now_ms;
            event_hit = 1'b1;
          end
        end else if (gt_deb) begin
          pressed_nxt = 1'b0;
          event_hit   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mark_r <= mark_nxt;
    if (!rst_n) begin
      pressed_r <= 1'b0;
    end else begin
      pressed_r <= pressed_nxt;
    end
  end

  generate
    if (AUTO_REPEAT) begin : g_held
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          held_r <= 1'b0;
        end else begin
          held_r <= held_nxt;
        end
      end
    end else begin : g_no_held
      assign held_r = 1'b0;
    end
  endgenerate

endmodule

// ===== hdl/bda_merge.sv =====
module bda_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [bda_pkg::NUM_BTN-1:0]         events,
  output logic                                can_push,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bda_pkg::OUT_DATA_W-1:0]      out_tdata
);

  logic [bda_pkg::OUT_DATA_W-1:0] word;
  logic [bda_pkg::OUT_DATA_W-1:0] data0_r;
  logic [bda_pkg::OUT_DATA_W-1:0] data0_nxt;
  logic [bda_pkg::OUT_DATA_W-1:0] data1_r;
  logic [bda_pkg::OUT_DATA_W-1:0] data1_nxt;
  logic [1:0]                     count_r;
  logic [1:0]                     count_nxt;
  logic                           pop;

  assign word       = {{(bda_pkg::OUT_DATA_W-bda_pkg::NUM_BTN){1'b0}}, events};
  assign out_tvalid = count_r != 2'd0;
  assign out_tdata  = data0_r;
  assign can_push   = count_r != 2'd2;
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    data0_nxt = data0_r;
    data1_nxt = data1_r;
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          data0_nxt = word;
        end else begin
          data1_nxt = word;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        data0_nxt = data1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          data0_nxt = word;
        end else begin
          data0_nxt = data1_r;
          data1_nxt = word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data0_r <= data0_nxt;
    data1_r <= data1_nxt;
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/button_debounce_autorepeat.sv =====
// Each result is registered in a two-entry output buffer before out_tvalid shows it.
// Throughput: one item per cycle while the output buffer has room; each of the four
// button lanes updates its state in the accept cycle, and the buffer absorbs stalls.
// Reset (rst_n low, synchronous) clears all pressed and held marks, empties the
// output buffer, and restores debounce_ms to 50 and repeat_ms to 300.
module button_debounce_autorepeat (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // now_ms[31:0], ok_level[32], cancel_level[33], left_level[34], right_level[35]
  input  logic [bda_pkg::IN_DATA_W-1:0]        in_tdata,
  // mode[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // ok_event[0], cancel_event[1], left_event[2], right_event[3]
  output logic [bda_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bda_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bda_pkg::CFG_W-1:0]            cfg_data
);

  bda_pkg::cfg_t                  cfg_r;
  bda_pkg::lane_ctl_t             ctl;
  logic [bda_pkg::NUM_BTN-1:0]    levels;
  logic [bda_pkg::NUM_BTN-1:0]    events;
  logic                           can_push;

  assign cfg_ready  = 1'b1;
  assign in_tready  = can_push;
  assign ctl.accept = in_tvalid && in_tready;
  assign ctl.mode   = in_tuser;
  assign ctl.now_ms = in_tdata[bda_pkg::TIME_W-1:0];
  assign levels     = in_tdata[bda_pkg::TIME_W +: bda_pkg::NUM_BTN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= bda_pkg::DEBOUNCE_RST;
      cfg_r.rpt_ms      <= bda_pkg::REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bda_pkg::REG_DEBOUNCE) begin
        cfg_r.debounce_ms <= cfg_data;
      end else if (cfg_index == bda_pkg::REG_REPEAT) begin
        cfg_r.rpt_ms <= cfg_data;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < bda_pkg::NUM_BTN; i++) begin : g_lane
      bda_lane #(
        .AUTO_REPEAT(i >= bda_pkg::KEY_LEFT)
      ) u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (cfg_r),
        .level     (levels[i]),
        .event_hit (events[i])
      );
    end
  endgenerate

  bda_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ctl.accept),
    .events     (events),
    .can_push   (can_push),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/tb_button_debounce_autorepeat.sv =====
module tb_button_debounce_autorepeat;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bda_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bda_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [3:0] ALL_RELEASED = 4'hF;
  localparam logic [3:0] ALL_PRESSED  = 4'h0;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic                       mode;
    logic [bda_pkg::TIME_W-1:0] now_ms;
    logic [3:0]                 level;
  } pin_item_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [bda_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           in_tuser   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bda_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [bda_pkg::CFG_W-1:0]      cfg_data   = '0;

  button_debounce_autorepeat dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pin_item_t   pin_items_q[$];
  logic [3:0]  events_due[$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;

  // Mirror of the block's state, updated on accepted transactions.
  logic [bda_pkg::CFG_W-1:0]  mirror_debounce;
  logic [bda_pkg::CFG_W-1:0]  mirror_repeat;
  logic [bda_pkg::TIME_W-1:0] btn_mark[bda_pkg::NUM_BTN];
  logic                       btn_down[bda_pkg::NUM_BTN];
  logic                       rep_held[2];

  // Stimulus-side view of the current settings and time line.
  int unsigned                gen_debounce = bda_pkg::DEBOUNCE_RST;
  int unsigned                gen_repeat = bda_pkg::REPEAT_RST;
  logic [bda_pkg::TIME_W-1:0] wall_ms;

  string event_names[bda_pkg::NUM_BTN] =
    '{"ok_event", "cancel_event", "left_event", "right_event"};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] debounce_step(input logic mode,
                                               input logic [bda_pkg::TIME_W-1:0] now,
                                               input logic [3:0] level);
    logic [3:0]                 fired;
    logic [bda_pkg::TIME_W-1:0] since;
    int                         h;
    fired = '0;
    for (int b = 0; b < bda_pkg::NUM_BTN; b++) begin
      h = b - int'(bda_pkg::KEY_LEFT);
      since = now - btn_mark[b];
      if (mode == bda_pkg::MODE_SAMPLE) begin
        if (!level[b]) begin
          if (!btn_down[b]) begin
            btn_mark[b] = now;
            btn_down[b] = 1'b1;
            if (b >= bda_pkg::KEY_LEFT) rep_held[h] = 1'b0;
          end
        end else begin
          btn_down[b] = 1'b0;
          if (b >= bda_pkg::KEY_LEFT) rep_held[h] = 1'b0;
        end
      end else if (b >= bda_pkg::KEY_LEFT) begin
        if (btn_down[b]) begin
          if (!rep_held[h]) begin
            if (since > {16'd0, mirror_debounce}) begin
              rep_held[h] = 1'b1;
              btn_mark[b] = now;
              fired[b] = 1'b1;
            end
          end else if (since > {16'd0, mirror_repeat}) begin
            btn_mark[b] = now;
            fired[b] = 1'b1;
          end
        end
      end else if (btn_down[b] && since > {16'd0, mirror_debounce}) begin
        btn_down[b] = 1'b0;
        fired[b] = 1'b1;
      end
    end
    return fired;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap    <= $urandom_range(0, 15);
        in_tvalid <= 1'b0;
      end else if (pin_items_q.size() > 0) begin
        pin_item_t item;
        item = pin_items_q.pop_front();
        in_tdata  <= {4'b0000, item.level, item.now_ms};
        in_tuser  <= item.mode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall  <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [3:0] want;
    logic [3:0] got;
    if (!rst_n) begin
      mirror_debounce = bda_pkg::DEBOUNCE_RST;
      mirror_repeat   = bda_pkg::REPEAT_RST;
      for (int b = 0; b < bda_pkg::NUM_BTN; b++) begin
        btn_mark[b] = '0;
        btn_down[b] = 1'b0;
      end
      rep_held[0] = 1'b0;
      rep_held[1] = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bda_pkg::REG_DEBOUNCE: mirror_debounce = cfg_data;
          bda_pkg::REG_REPEAT:   mirror_repeat = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        events_due.push_back(debounce_step(in_tuser, in_tdata[bda_pkg::TIME_W-1:0],
                                           in_tdata[bda_pkg::TIME_W+3:bda_pkg::TIME_W]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[3:0];
        if (events_due.size() == 0) begin
          $error("result transaction with no expected result, tdata=%h", out_tdata);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          for (int b = 0; b < bda_pkg::NUM_BTN; b++)
            if (got[b] !== want[b]) begin
              $error("%s: expected %0b, actual %0b", event_names[b], want[b], got[b]);
              mismatches++;
            end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_item(input logic mode, input logic [bda_pkg::TIME_W-1:0] now,
                                   input logic [3:0] level);
    pin_item_t item;
    item.mode   = mode;
    item.now_ms = now;
    item.level  = level;
    pin_items_q.push_back(item);
  endfunction

  function automatic logic [bda_pkg::TIME_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return gen_debounce;
      1: return gen_debounce + 1;
      2: return gen_repeat;
      3: return gen_repeat + 1;
      4: return $urandom_range(0, 3);
      5: return $urandom;
      default: return $urandom_range(0, 2 * (gen_debounce + gen_repeat) + 2);
    endcase
  endfunction

  // A press of some buttons, a run of polls with the odd re-sample or toggle,
  // and usually a release of everything at the end.
  function automatic void queue_session();
    logic [3:0]  held_lvl;
    int unsigned polls;
    held_lvl = 4'($urandom_range(0, 14));
    polls = $urandom_range(2, 10);
    add_item(bda_pkg::MODE_SAMPLE, wall_ms, held_lvl);
    repeat (polls) begin
      wall_ms += pick_step();
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 0) held_lvl[$urandom_range(0, 3)] ^= 1'b1;
        add_item(bda_pkg::MODE_SAMPLE, wall_ms, held_lvl);
      end else begin
        add_item(bda_pkg::MODE_POLL, wall_ms, 4'($urandom));
      end
    end
    if ($urandom_range(0, 2) != 0) begin
      wall_ms += pick_step();
      add_item(bda_pkg::MODE_SAMPLE, wall_ms, ALL_RELEASED);
    end
  endfunction

  task automatic write_reg(input logic [bda_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bda_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bda_pkg::REG_DEBOUNCE: gen_debounce = {16'd0, val};
      bda_pkg::REG_REPEAT:   gen_repeat = {16'd0, val};
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pin_items_q.size() != 0 || in_tvalid || events_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [bda_pkg::TIME_W-1:0] t0;
    int unsigned                deb_set[NUM_PHASES];
    int unsigned                rep_set[NUM_PHASES];
    deb_set = '{0, 65535, 1, 0, 65535, 7, 0, 50};
    rep_set = '{0, 65535, 2, 65535, 0, 20, 0, 300};
    deb_set[6] = $urandom_range(0, 400);
    rep_set[6] = $urandom_range(0, 400);
    wall_ms = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: strict threshold, wrap of the time counter, repeat of
    // left and right, re-press of ok and cancel while still held.
    t0 = 32'hFFFF_FFF0;
    add_item(bda_pkg::MODE_POLL,   32'd0,         ALL_RELEASED);
    add_item(bda_pkg::MODE_SAMPLE, t0,            ALL_PRESSED);
    add_item(bda_pkg::MODE_POLL,   t0 + 50,       ALL_PRESSED);
    add_item(bda_pkg::MODE_POLL,   t0 + 51,       ALL_RELEASED);
    add_item(bda_pkg::MODE_POLL,   t0 + 351,      ALL_PRESSED);
    add_item(bda_pkg::MODE_POLL,   t0 + 352,      ALL_PRESSED);
    add_item(bda_pkg::MODE_SAMPLE, t0 + 352,      ALL_PRESSED);
    add_item(bda_pkg::MODE_POLL,   t0 + 403,      ALL_PRESSED);
    add_item(bda_pkg::MODE_SAMPLE, t0 + 410,      4'b0101);
    add_item(bda_pkg::MODE_POLL,   t0 + 461,      4'b1010);
    add_item(bda_pkg::MODE_POLL,   t0 + 653,      ALL_PRESSED);
    add_item(bda_pkg::MODE_SAMPLE, 32'hFFFF_FFFF, ALL_RELEASED);
    add_item(bda_pkg::MODE_POLL,   32'hFFFF_FFFF, ALL_PRESSED);
    add_item(bda_pkg::MODE_SAMPLE, 32'd1000,      ALL_PRESSED);
    add_item(bda_pkg::MODE_POLL,   32'd999,       ALL_PRESSED);
    add_item(bda_pkg::MODE_SAMPLE, 32'd0,         ALL_RELEASED);
    add_item(bda_pkg::MODE_POLL,   32'd0,         ALL_RELEASED);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(bda_pkg::REG_DEBOUNCE, 16'(deb_set[p]));
      write_reg(bda_pkg::REG_REPEAT, 16'(rep_set[p]));
      if ($urandom_range(0, 1) == 0) write_reg(REG_SPARE_A, 16'($urandom));
      if ($urandom_range(0, 1) == 0) write_reg(REG_SPARE_B, 16'($urandom));
      if (p == NUM_PHASES - 1) calm = 1'b1;
      @(negedge clk);
      while (pin_items_q.size() < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0)
          add_item(logic'($urandom_range(0, 1)), $urandom, 4'($urandom));
        else
          queue_session();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== button_debounce_autorepeat.f =====
hdl/bda_pkg.sv
hdl/bda_lane.sv
hdl/bda_merge.sv
hdl/button_debounce_autorepeat.sv
dv/tb_button_debounce_autorepeat.sv
